@@ rtl/core/wlp_pkg.sv @@
// Package for the waypoint list pool: constants, payload structs, FSM state type
// and controller/datapath command and status structs. No dependencies.
package wlp_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = 7;
    localparam int ID_W       = 15;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_GET    = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [ID_W-1:0]   target_id;
    } wlp_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    result_id;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [CNT_W-1:0]   entry_count;
    } wlp_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_FREE,
        S_APPEND,
        S_RD_HEAD,
        S_CHK_HEAD,
        S_CHK_TAIL,
        S_WALK_RD,
        S_WALK_CHK,
        S_UNLINK_NEXT,
        S_UNLINK_PREV,
        S_REPORT
    } wlp_state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_HEAD,
        RD_TAIL,
        RD_CUR,
        RD_PREV_OF_CUR
    } wlp_rdsel_t;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       scan_step;
        logic       do_append;
        wlp_rdsel_t rd_sel;
        logic       del_head;
        logic       del_tail;
        logic       walk_start;
        logic       walk_step;
        logic       unlink_next;
        logic       unlink_prev;
        logic [1:0] set_status;
        logic       set_status_en;
        logic       report;
    } wlp_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       scan_free;
        logic       scan_done;
        logic       empty;
        logic       rd_match;
        logic       walk_done;
    } wlp_stat_t;

endpackage

@@ rtl/core/wlp_datapath.sv @@
// Datapath of the waypoint list pool: slot memories, head/tail/count/id
// registers, scan and walk counters. Depends on wlp_pkg.
module wlp_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  wlp_pkg::wlp_in_t  item,
    input  wlp_pkg::wlp_cmd_t cmd,
    output wlp_pkg::wlp_stat_t stat,
    output wlp_pkg::wlp_out_t result,
    output logic              strobe
);
    import wlp_pkg::*;

    logic [47:0]      coords_mem [POOL_DEPTH];
    logic [ID_W-1:0]  ident_mem  [POOL_DEPTH];
    logic [IDX_W-1:0] prev_mem   [POOL_DEPTH];
    logic [IDX_W-1:0] next_mem   [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] used_reg;

    wlp_in_t          item_reg;
    logic [IDX_W-1:0] head_reg, tail_reg, cur_reg, slot_reg;
    logic [CNT_W-1:0] count_reg, walk_reg;
    logic [ID_W-1:0]  ident_reg;
    logic [IDX_W:0]   scan_reg;
    logic [1:0]       status_reg;
    wlp_out_t         result_reg;
    logic             strobe_reg;

    logic [47:0]      rd_coords;
    logic [ID_W-1:0]  rd_ident;
    logic [IDX_W-1:0] rd_prev, rd_next;
    logic [IDX_W-1:0] rd_addr;

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HEAD:        rd_addr = head_reg;
            RD_TAIL:        rd_addr = tail_reg;
            RD_CUR:         rd_addr = cur_reg;
            RD_PREV_OF_CUR: rd_addr = rd_prev;
            default:        rd_addr = cur_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_coords   <= coords_mem[rd_addr];
        rd_ident    <= ident_mem[rd_addr];
        rd_prev     <= prev_mem[rd_addr];
        rd_next     <= next_mem[rd_addr];
        if (cmd.do_append)
        begin
            coords_mem[slot_reg] <= {item_reg.pos_z, item_reg.pos_y, item_reg.pos_x};
            ident_mem[slot_reg]  <= ident_reg;
            next_mem[slot_reg]   <= '0;
            prev_mem[slot_reg]   <= (count_reg == '0) ? '0 : tail_reg;
        end
        if (cmd.do_append && count_reg != '0)
            next_mem[tail_reg] <= slot_reg;
        if (cmd.unlink_next)
            next_mem[rd_prev] <= rd_next;
        if (cmd.unlink_prev)
            prev_mem[rd_next] <= slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            ident_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.report;
            if (cmd.clear)
            begin
                used_reg  <= '0;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
                ident_reg <= '0;
            end
            if (cmd.do_append)
            begin
                used_reg[slot_reg] <= 1'b1;
                ident_reg <= ident_reg + 1'b1;
                tail_reg  <= slot_reg;
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0)
                    head_reg <= slot_reg;
            end
            if (cmd.del_head)
            begin
                used_reg[head_reg] <= 1'b0;
                count_reg <= count_reg - 1'b1;
                if (count_reg > CNT_W'(1))
                    head_reg <= rd_next;
            end
            if (cmd.del_tail)
            begin
                used_reg[tail_reg] <= 1'b0;
                count_reg <= count_reg - 1'b1;
                tail_reg  <= rd_prev;
            end
            if (cmd.unlink_next)
            begin
                used_reg[cur_reg] <= 1'b0;
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            scan_reg <= '0;
        end
        if (cmd.scan_step)
            scan_reg <= scan_reg + 1'b1;
        if (cmd.scan_step && !used_reg[scan_reg[IDX_W-1:0]])
            slot_reg <= scan_reg[IDX_W-1:0];
        if (cmd.walk_start)
        begin
            cur_reg  <= head_reg;
            walk_reg <= '0;
        end
        if (cmd.walk_step)
        begin
            cur_reg  <= rd_next;
            walk_reg <= walk_reg + 1'b1;
        end
        if (cmd.unlink_next)
            slot_reg <= rd_prev;
        if (cmd.set_status_en)
            status_reg <= cmd.set_status;
        if (cmd.report)
        begin
            result_reg.status      <= status_reg;
            result_reg.entry_count <= count_reg;
            result_reg.result_id   <= '0;
            result_reg.out_x       <= '0;
            result_reg.out_y       <= '0;
            result_reg.out_z       <= '0;
            if (status_reg == ST_OK && item_reg.action == ACT_APPEND)
                result_reg.result_id <= ident_reg - 1'b1;
            if (status_reg == ST_OK && item_reg.action == ACT_GET)
            begin
                result_reg.result_id <= rd_ident;
                result_reg.out_x     <= rd_coords[15:0];
                result_reg.out_y     <= rd_coords[31:16];
                result_reg.out_z     <= rd_coords[47:32];
            end
        end
    end

    assign stat.action    = item_reg.action;
    assign stat.scan_free = !used_reg[scan_reg[IDX_W-1:0]];
    assign stat.scan_done = (scan_reg == (IDX_W+1)'(POOL_DEPTH - 1));
    assign stat.empty     = (count_reg == '0);
    assign stat.rd_match  = (rd_ident == item_reg.target_id);
    assign stat.walk_done = (walk_reg == count_reg);
    assign result = result_reg;
    assign strobe = strobe_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_DEPTH))
        else $error("entry count beyond pool depth");
    a_count_ones: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(count_reg))
        else $error("used bits disagree with count");
    a_append_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_append |-> !used_reg[slot_reg])
        else $error("append into used slot");
`endif
endmodule

@@ rtl/core/wlp_ctrl.sv @@
// Controller state machine of the waypoint list pool; sequences scans, walks
// and unlinks through the datapath. Depends on wlp_pkg.
module wlp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wlp_pkg::wlp_in_t   item,
    input  wlp_pkg::wlp_stat_t stat,
    output wlp_pkg::wlp_cmd_t  cmd
);
    import wlp_pkg::*;

    wlp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    unique case (item.action)
                        ACT_APPEND: state_next = S_SCAN_FREE;
                        ACT_DELETE: state_next = S_RD_HEAD;
                        ACT_GET:    state_next = S_RD_HEAD;
                        default:
                        begin
                            cmd.clear         = 1'b1;
                            cmd.set_status_en = 1'b1;
                            cmd.set_status    = ST_OK;
                            state_next        = S_REPORT;
                        end
                    endcase
                end
            end
            S_SCAN_FREE:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_free)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.set_status    = ST_OK;
                    state_next        = S_APPEND;
                end
                else if (stat.scan_done)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.set_status    = ST_FULL;
                    state_next        = S_REPORT;
                end
            end
            S_APPEND:
            begin
                cmd.do_append = 1'b1;
                state_next    = S_REPORT;
            end
            S_RD_HEAD:
            begin
                cmd.walk_start = 1'b1;
                if (stat.empty)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.set_status    = ST_NOT_FOUND;
                    state_next        = S_REPORT;
                end
                else if (stat.action == ACT_GET)
                    state_next = S_WALK_RD;
                else
                begin
                    cmd.rd_sel = RD_HEAD;
                    state_next = S_CHK_HEAD;
                end
            end
            S_CHK_HEAD:
            begin
                cmd.rd_sel = RD_TAIL;
                if (stat.rd_match)
                begin
                    cmd.del_head      = 1'b1;
                    cmd.set_status_en = 1'b1;
                    cmd.set_status    = ST_OK;
                    state_next        = S_REPORT;
                end
                else
                    state_next = S_CHK_TAIL;
            end
            S_CHK_TAIL:
            begin
                if (stat.rd_match)
                begin
                    cmd.del_tail      = 1'b1;
                    cmd.set_status_en = 1'b1;
                    cmd.set_status    = ST_OK;
                    state_next        = S_REPORT;
                end
                else
                    state_next = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                cmd.rd_sel = RD_CUR;
                if (stat.walk_done)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.set_status    = ST_NOT_FOUND;
                    state_next        = S_REPORT;
                end
                else
                    state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (stat.rd_match)
                begin
                    cmd.set_status_en = 1'b1;
                    cmd.set_status    = ST_OK;
                    state_next = (stat.action == ACT_GET) ? S_REPORT : S_UNLINK_NEXT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_UNLINK_NEXT:
            begin
                // write next[prev]=next, latch prev in slot_reg, hold cur's entry
                cmd.unlink_next = 1'b1;
                cmd.rd_sel      = RD_CUR;
                state_next      = S_UNLINK_PREV;
            end
            S_UNLINK_PREV:
            begin
                cmd.unlink_prev = 1'b1;
                state_next      = S_REPORT;
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> state_reg == S_IDLE)
        else $error("report not followed by idle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy)
        else $error("load while busy");
    a_one_del: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.del_head, cmd.del_tail, cmd.unlink_next, cmd.do_append}) <= 1)
        else $error("conflicting list updates");
`endif
endmodule

@@ rtl/core/waypoint_list_pool.sv @@
// Waypoint list pool: doubly linked list of waypoints in a fixed slot pool.
// Throughput: one command at a time; start is taken only while busy is low.
// Result is on result for one cycle with done, the first cycle busy is low; no stall.
// Reset: asynchronous active-low rst_n empties the list and zeroes the ID counter.
// Depends on wlp_pkg, wlp_ctrl, wlp_datapath.
module waypoint_list_pool (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  wlp_pkg::wlp_in_t  item,
    output logic              done,
    output wlp_pkg::wlp_out_t result
);
    import wlp_pkg::*;

    wlp_cmd_t  cmd;
    wlp_stat_t stat;

    wlp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .stat  (stat),
        .cmd   (cmd)
    );

    wlp_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .strobe (done)
    );
endmodule

@@ bench/tb.sv @@
// Self-checking testbench for waypoint_list_pool: directed table and random
// traffic, checked against table values or an in-bench list predictor.
// Depends on wlp_pkg and the waypoint_list_pool RTL.
`timescale 1ns / 1ps

module tb;
    import wlp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_ITEMS     = 500;

    typedef struct {
        wlp_in_t  cmd;
        bit       typed;
        wlp_out_t want;
    } vector_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    wlp_in_t  item;
    logic     done;
    wlp_out_t result;

    logic [47:0]     pool_coords [POOL_DEPTH];
    logic [ID_W-1:0] pool_ident  [POOL_DEPTH];
    bit              pool_used   [POOL_DEPTH];
    int              pool_prev   [POOL_DEPTH];
    int              pool_next   [POOL_DEPTH];
    int              list_head;
    int              list_tail;
    int              list_count;
    logic [ID_W-1:0] ident_ctr;

    wlp_out_t        pending_results [$];
    int              mismatches;
    int              idle_cycles;
    int              act_seen [4];
    int              full_seen;
    int              miss_seen;

    waypoint_list_pool i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void pool_reset();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            pool_used[i] = 1'b0;
        end
        list_head  = 0;
        list_tail  = 0;
        list_count = 0;
        ident_ctr  = '0;
    endfunction

    function automatic bit locate_ident(input logic [ID_W-1:0] id, output int where);
        int cur;
        cur   = list_head;
        where = 0;
        for (int n = 0; n < list_count; n++)
        begin
            if (pool_ident[cur] == id)
            begin
                where = cur;
                return 1'b1;
            end
            cur = pool_next[cur];
        end
        return 1'b0;
    endfunction

    function automatic void release_slot(input int s);
        pool_used[s] = 1'b0;
        if (list_count > 0)
            list_count--;
    endfunction

    function automatic wlp_out_t apply_list_op(input wlp_in_t cmd);
        wlp_out_t r;
        int       s;
        int       p;
        int       n;
        r = '0;
        case (cmd.action)
            ACT_APPEND:
            begin
                s = 0;
                while (s < POOL_DEPTH && pool_used[s])
                    s++;
                if (s >= POOL_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pool_used[s]   = 1'b1;
                    pool_coords[s] = {cmd.pos_z, cmd.pos_y, cmd.pos_x};
                    pool_ident[s]  = ident_ctr;
                    r.result_id    = ident_ctr;
                    ident_ctr      = ident_ctr + 1'b1;
                    pool_next[s]   = 0;
                    if (list_count == 0)
                    begin
                        list_head    = s;
                        list_tail    = s;
                        pool_prev[s] = 0;
                    end
                    else
                    begin
                        pool_next[list_tail] = s;
                        pool_prev[s]         = list_tail;
                        list_tail            = s;
                    end
                    list_count++;
                end
            end
            ACT_DELETE:
            begin
                if (list_count == 0)
                    r.status = ST_NOT_FOUND;
                else if (pool_ident[list_head] == cmd.target_id)
                begin
                    s = list_head;
                    if (list_count > 1)
                        list_head = pool_next[s];
                    release_slot(s);
                end
                else if (pool_ident[list_tail] == cmd.target_id)
                begin
                    s = list_tail;
                    list_tail = pool_prev[s];
                    release_slot(s);
                end
                else if (locate_ident(cmd.target_id, s))
                begin
                    p = pool_prev[s];
                    n = pool_next[s];
                    pool_next[p] = n;
                    pool_prev[n] = p;
                    release_slot(s);
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            ACT_GET:
            begin
                if (locate_ident(cmd.target_id, s))
                begin
                    r.result_id = pool_ident[s];
                    r.out_x     = pool_coords[s][15:0];
                    r.out_y     = pool_coords[s][31:16];
                    r.out_z     = pool_coords[s][47:32];
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
                pool_reset();
        endcase
        r.entry_count = list_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // Drive start low for the gap, then raise it and leave it high until a later gapped issue or drain drops it.
    task automatic issue(input wlp_in_t cmd, input int gap, input bit typed,
                         input wlp_out_t want);
        wlp_out_t pred;
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        item  = cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = apply_list_op(cmd);
        if (cmd.action == ACT_APPEND && pred.status == ST_FULL)
            full_seen++;
        if (pred.status == ST_NOT_FOUND)
            miss_seen++;
        act_seen[cmd.action]++;
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic wlp_in_t random_cmd(input int append_pct);
        wlp_in_t c;
        int      roll;
        int      pick;
        int      cur;
        c.pos_x     = 16'($urandom);
        c.pos_y     = 16'($urandom);
        c.pos_z     = 16'($urandom);
        c.target_id = ID_W'($urandom);
        roll        = int'($urandom_range(99));
        if (roll < append_pct)
            c.action = ACT_APPEND;
        else if (roll < 99)
            c.action = ($urandom_range(1)) ? ACT_DELETE : ACT_GET;
        else
            c.action = ACT_CLEAR;
        if (c.action != ACT_APPEND && list_count > 0 && $urandom_range(9) < 8)
        begin
            pick = int'($urandom_range(list_count - 1));
            cur  = list_head;
            repeat (pick) cur = pool_next[cur];
            c.target_id = pool_ident[cur];
        end
        return c;
    endfunction

    always @(posedge clk)
    begin
        wlp_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", int'(result.status), int'(want.status));
                if (result.result_id !== want.result_id)
                    report_mismatch("result_id", int'(result.result_id),
                                    int'(want.result_id));
                if (result.out_x !== want.out_x)
                    report_mismatch("out_x", int'(result.out_x), int'(want.out_x));
                if (result.out_y !== want.out_y)
                    report_mismatch("out_y", int'(result.out_y), int'(want.out_y));
                if (result.out_z !== want.out_z)
                    report_mismatch("out_z", int'(result.out_z), int'(want.out_z));
                if (result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", int'(result.entry_count),
                                    int'(want.entry_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic vector_t row(input logic [1:0] act, input int x, input int y,
                                    input int z, input int id, input bit typed,
                                    input int st, input int rid, input int cnt);
        vector_t v;
        v.cmd.action           = act;
        v.cmd.pos_x            = 16'(x);
        v.cmd.pos_y            = 16'(y);
        v.cmd.pos_z            = 16'(z);
        v.cmd.target_id        = ID_W'(id);
        v.typed                = typed;
        v.want                 = '0;
        v.want.status          = 2'(st);
        v.want.result_id       = ID_W'(rid);
        v.want.entry_count     = CNT_W'(cnt);
        return v;
    endfunction

    initial
    begin
        vector_t  vectors [$];
        vector_t  v;
        wlp_in_t  c;
        wlp_out_t w;
        int       no_gap;

        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        mismatches  = 0;
        idle_cycles = 0;
        full_seen   = 0;
        miss_seen   = 0;
        act_seen    = '{default: 0};
        pool_reset();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        vectors.push_back(row(ACT_GET,    0, 0, 0, 0,     1, ST_NOT_FOUND, 0, 0));
        vectors.push_back(row(ACT_DELETE, 0, 0, 0, 0,     1, ST_NOT_FOUND, 0, 0));
        vectors.push_back(row(ACT_APPEND, -32768, -32768, -32768, 0, 1, ST_OK, 0, 1));
        vectors.push_back(row(ACT_APPEND, 32767, 32767, 32767, 32767, 1, ST_OK, 1, 2));
        vectors.push_back(row(ACT_APPEND, -1, 0, 1, 0,    1, ST_OK, 2, 3));
        vectors.push_back(row(ACT_APPEND, 1234, -4321, 77, 0, 1, ST_OK, 3, 4));
        vectors.push_back(row(ACT_GET,    0, 0, 0, 0,     0, 0, 0, 0));
        vectors.push_back(row(ACT_GET,    0, 0, 0, 1,     0, 0, 0, 0));
        vectors.push_back(row(ACT_GET,    0, 0, 0, 32767, 1, ST_NOT_FOUND, 0, 4));
        vectors.push_back(row(ACT_DELETE, 0, 0, 0, 2,     1, ST_OK, 0, 3));
        vectors.push_back(row(ACT_DELETE, 0, 0, 0, 3,     1, ST_OK, 0, 2));
        vectors.push_back(row(ACT_DELETE, 0, 0, 0, 0,     1, ST_OK, 0, 1));
        vectors.push_back(row(ACT_GET,    0, 0, 0, 1,     0, 0, 0, 0));
        vectors.push_back(row(ACT_APPEND, 5, 6, 7, 0,     1, ST_OK, 4, 2));
        vectors.push_back(row(ACT_APPEND, 8, 9, 10, 0,    1, ST_OK, 5, 3));
        vectors.push_back(row(ACT_DELETE, 0, 0, 0, 4,     1, ST_OK, 0, 2));
        vectors.push_back(row(ACT_GET,    0, 0, 0, 5,     0, 0, 0, 0));
        vectors.push_back(row(ACT_DELETE, 0, 0, 0, 1,     1, ST_OK, 0, 1));
        vectors.push_back(row(ACT_DELETE, 0, 0, 0, 5,     1, ST_OK, 0, 0));
        vectors.push_back(row(ACT_DELETE, 0, 0, 0, 5,     1, ST_NOT_FOUND, 0, 0));
        vectors.push_back(row(ACT_APPEND, 0, 0, 0, 0,     1, ST_OK, 6, 1));
        vectors.push_back(row(ACT_CLEAR,  0, 0, 0, 0,     1, ST_OK, 0, 0));
        vectors.push_back(row(ACT_APPEND, 100, 200, 300, 0, 1, ST_OK, 0, 1));
        vectors.push_back(row(ACT_GET,    0, 0, 0, 0,     0, 0, 0, 0));

        foreach (vectors[i])
        begin
            v = vectors[i];
            issue(v.cmd, $urandom_range(11), v.typed, v.want);
        end
        drain();

        // Fill past capacity, then random mix with gapped and gapless stretches.
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            no_gap = ((n / 50) % 3 == 1);
            c = random_cmd((n < 120 || (n >= 400 && n < 480)) ? 90 : 45);
            w = '0;
            issue(c, no_gap ? 0 : $urandom_range(11), 1'b0, w);
            if (n % 173 == 0)
                drain();
        end
        drain();

        // Trim to a few entries, refill, then a mix with small IDs.
        while (list_count > 6)
        begin
            c = random_cmd(0);
            c.action    = ACT_DELETE;
            c.target_id = pool_ident[list_head];
            issue(c, 0, 1'b0, w);
        end
        for (int n = 0; n < 8; n++)
        begin
            c = random_cmd(100);
            issue(c, 0, 1'b0, w);
        end
        for (int n = 0; n < 150; n++)
        begin
            c = random_cmd(35);
            if (c.action == ACT_CLEAR)
                c.action = ACT_GET;
            if ($urandom_range(3) == 0)
                c.target_id = ID_W'($urandom_range(25));
            issue(c, $urandom_range(11), 1'b0, w);
        end
        drain();
        repeat (200) @(posedge clk);

        $display("covered %0d appends, %0d deletes, %0d gets, %0d clears",
                 act_seen[ACT_APPEND], act_seen[ACT_DELETE], act_seen[ACT_GET],
                 act_seen[ACT_CLEAR]);
        $display("pool full %0d times, id misses %0d, head/tail/middle unlinks mixed",
                 full_seen, miss_seen);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
